// ----- rtl/core/sscd_pkg.sv -----
// Shared types, constants and digit functions of the switch-count seven-segment driver.
package sscd_pkg;

  localparam int MAX_PAIRS_DEFAULT = 4;

  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_PAIRS  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_INPUT_MASK = 1'b1;

  localparam logic [2:0] NUM_PAIRS_RESET  = 3'd2;
  localparam logic [7:0] INPUT_MASK_RESET = 8'hFF;
  localparam logic [7:0] SEG_BLANK        = 8'hFF;

  typedef struct packed {
    logic accept;     // input item taken this cycle
    logic load;       // load the output register with the current digit
    logic sent;       // output item taken this cycle
  } cmd_t;

  typedef struct packed {
    logic frame_change;  // accepted item ends a frame in which some count changed
    logic out_last;      // output register holds the final digit of the run
  } status_t;

  function automatic logic [3:0] pop8(input logic [7:0] v);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < 8; i++) begin
      n = n + 4'(v[i]);
    end
    return n;
  endfunction

  function automatic logic [3:0] tens_of(input logic [4:0] c);
    logic [3:0] t;
    if (c >= 5'd30) begin
      t = 4'd3;
    end else if (c >= 5'd20) begin
      t = 4'd2;
    end else if (c >= 5'd10) begin
      t = 4'd1;
    end else begin
      t = 4'd0;
    end
    return t;
  endfunction

  function automatic logic [3:0] units_of(input logic [4:0] c);
    logic [4:0] u;
    if (c >= 5'd30) begin
      u = c - 5'd30;
    end else if (c >= 5'd20) begin
      u = c - 5'd20;
    end else if (c >= 5'd10) begin
      u = c - 5'd10;
    end else begin
      u = c;
    end
    return u[3:0];
  endfunction

  // Active-low segment pattern; anything above nine blanks the digit.
  function automatic logic [7:0] seg_code(input logic [3:0] d);
    logic [7:0] s;
    unique case (d)
      4'd0:    s = 8'h40;
      4'd1:    s = 8'hF9;
      4'd2:    s = 8'h24;
      4'd3:    s = 8'h30;
      4'd4:    s = 8'h19;
      4'd5:    s = 8'h12;
      4'd6:    s = 8'h02;
      4'd7:    s = 8'h78;
      4'd8:    s = 8'h00;
      4'd9:    s = 8'h10;
      default: s = SEG_BLANK;
    endcase
    return s;
  endfunction

endpackage

// ----- rtl/core/sscd_ctrl.sv -----
// Controller state machine: byte intake, digit load and digit send.
module sscd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  output logic              m_tvalid,
  input  logic              m_tready,
  input  sscd_pkg::status_t sts,
  output sscd_pkg::cmd_t    cmd
);

  localparam logic [1:0] S_IN   = 2'd0;
  localparam logic [1:0] S_LOAD = 2'd1;
  localparam logic [1:0] S_SEND = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    s_tready   = (state == S_IN);
    m_tvalid   = (state == S_SEND);
    cmd.accept = s_tready & s_tvalid;
    cmd.load   = (state == S_LOAD);
    cmd.sent   = m_tvalid & m_tready;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IN: begin
        if (cmd.accept && sts.frame_change) begin
          state_next = S_LOAD;
        end
      end
      S_LOAD: begin
        state_next = S_SEND;
      end
      S_SEND: begin
        if (cmd.sent) begin
          state_next = sts.out_last ? S_IN : S_LOAD;
        end
      end
      default: begin
        state_next = S_IN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IN;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- rtl/core/sscd_dp.sv -----
// Datapath: config registers, pair counting, stored counts and digit output register.
module sscd_dp #(
  parameter int MAX_PAIRS = sscd_pkg::MAX_PAIRS_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [sscd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sscd_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic [7:0]                        in_byte,
  input  sscd_pkg::cmd_t                    cmd,
  output sscd_pkg::status_t                 sts,
  output logic [7:0]                        out_seg,
  output logic [2:0]                        out_pos,
  output logic [4:0]                        out_count,
  output logic                              out_chg,
  output logic                              out_last
);

  localparam int PW = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;

  logic [2:0]           num_pairs;
  logic [7:0]           input_mask;
  logic                 byte_odd;
  logic [PW-1:0]        pair_idx;
  logic [3:0]           partial;
  logic [MAX_PAIRS-1:0] changed;
  logic [4:0]           stored [MAX_PAIRS];
  logic [PW-1:0]        emit_pair;
  logic                 emit_k;

  logic [PW-1:0]        last_pair;
  logic [PW-1:0]        rd_pair;
  logic [4:0]           rd_count;
  logic [4:0]           cnt;
  logic                 diff;
  logic [MAX_PAIRS-1:0] changed_now;
  logic                 frame_end;
  logic [3:0]           digit;

  always_comb begin
    if (num_pairs == 3'd0) begin
      last_pair = '0;
    end else if (32'(num_pairs) > MAX_PAIRS) begin
      last_pair = PW'(MAX_PAIRS - 1);
    end else begin
      last_pair = PW'(num_pairs - 3'd1);
    end
  end

  // Single read port: run position while loading a digit, frame position otherwise.
  assign rd_pair  = cmd.load ? emit_pair : pair_idx;
  assign rd_count = stored[rd_pair];

  assign cnt         = 5'(partial) + 5'(sscd_pkg::pop8(in_byte & input_mask));
  assign diff        = (cnt != rd_count);
  assign changed_now = changed | (diff ? (MAX_PAIRS'(1) << pair_idx) : '0);
  assign frame_end   = byte_odd && (pair_idx == last_pair);

  assign sts.frame_change = frame_end && (changed_now != '0);
  assign sts.out_last     = out_last;

  assign digit = emit_k ? sscd_pkg::units_of(rd_count) : sscd_pkg::tens_of(rd_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      num_pairs  <= sscd_pkg::NUM_PAIRS_RESET;
      input_mask <= sscd_pkg::INPUT_MASK_RESET;
      byte_odd   <= 1'b0;
      pair_idx   <= '0;
      partial    <= '0;
      changed    <= '0;
      emit_pair  <= '0;
      emit_k     <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          sscd_pkg::CFG_NUM_PAIRS: begin
            num_pairs <= cfg_data[2:0];
            byte_odd  <= 1'b0;
            pair_idx  <= '0;
            partial   <= '0;
            changed   <= '0;
          end
          sscd_pkg::CFG_INPUT_MASK: begin
            input_mask <= cfg_data;
          end
          default: begin
          end
        endcase
      end
      if (cmd.accept) begin
        emit_pair <= '0;
        emit_k    <= 1'b0;
        if (!byte_odd) begin
          partial  <= sscd_pkg::pop8(in_byte);
          byte_odd <= 1'b1;
        end else if (!frame_end) begin
          changed  <= changed_now;
          byte_odd <= 1'b0;
          pair_idx <= pair_idx + PW'(1);
        end else begin
          // frame end: flags stay only while the digit run is pending
          changed  <= sts.frame_change ? changed_now : '0;
          byte_odd <= 1'b0;
          pair_idx <= '0;
          partial  <= '0;
        end
      end
      if (cmd.sent) begin
        if (out_last) begin
          changed <= '0;
        end else if (emit_k) begin
          emit_k    <= 1'b0;
          emit_pair <= emit_pair + PW'(1);
        end else begin
          emit_k <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_PAIRS; i++) begin
        stored[i] <= '0;
      end
    end else if (cmd.accept && byte_odd && diff) begin
      stored[pair_idx] <= cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_seg   <= sscd_pkg::seg_code(digit);
      out_pos   <= 3'({emit_pair, emit_k});
      out_count <= rd_count;
      out_chg   <= changed[emit_pair];
      out_last  <= (emit_pair == last_pair) && emit_k;
    end
  end

endmodule

// ----- rtl/core/switch_count_seven_segment_driver.sv -----
// Top level of the switch-count seven-segment driver.
//
//   channel   direction  payload
//   s_*       in         tdata[7:0] switch_byte
//   m_*       out        tdata: segment_code, digit_position, pair_count; tuser: pair_changed;
//                        tlast: last_digit
//   cfg_*     in         index 0 num_pairs, index 1 input_mask
//
// Even bytes and frame ends without a change give no item.
// A frame end with a change starts a run of 2*pairs digits, each loaded and then sent
// after any output stall; no byte is taken during the run.
// Stored counts, config and the frame position are set by the synchronous reset.
// A num_pairs write drops the frame in progress.
module switch_count_seven_segment_driver #(
  parameter int MAX_PAIRS = sscd_pkg::MAX_PAIRS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [7:0]                      s_tdata,   // [7:0] switch_byte
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [15:0]                     m_tdata,   // [7:0] segment_code, [10:8] digit_position,
                                                     // [15:11] pair_count
  output logic                            m_tuser,   // [0] pair_changed
  output logic                            m_tlast,
  input  logic                            cfg_we,
  input  logic [sscd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sscd_pkg::CFG_DATA_W-1:0] cfg_data
);

  sscd_pkg::cmd_t    cmd;
  sscd_pkg::status_t sts;
  logic [7:0]        out_seg;
  logic [2:0]        out_pos;
  logic [4:0]        out_count;

  sscd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sscd_dp #(
    .MAX_PAIRS (MAX_PAIRS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_byte   (s_tdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_seg   (out_seg),
    .out_pos   (out_pos),
    .out_count (out_count),
    .out_chg   (m_tuser),
    .out_last  (m_tlast)
  );

  assign m_tdata = {out_count, out_pos, out_seg};

endmodule

// ----- rtl/core/sscd_chk.sv -----
// Port-level checker of the switch-count seven-segment driver, bound to the top level.
module sscd_chk (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic        m_tlast
);

  // A held output item keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output item changed while stalled");

  // No byte is taken while a digit run is being shown.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input ready during digit run");

  // Input reopens right after the final digit goes out.
  a_run_end: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tlast |=> s_tready && !m_tvalid)
    else $error("input not reopened after last digit");

  // Nothing is shown out of reset.
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("output valid after reset");

  // A pair count never exceeds sixteen.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[15:11] <= 5'd16)
    else $error("pair count out of range");

endmodule

bind switch_count_seven_segment_driver sscd_chk u_sscd_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
